// ----- src/ltc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ltc_pkg;

    // Cache geometry.
    localparam int LTC_WAYS       = 64;
    localparam int LTC_TILE_BYTES = 512;

    // Field widths of the words on both channels.
    localparam int LTC_COORD_W    = 11;
    localparam int LTC_TILE_W     = 10;
    localparam int LTC_SLOT_OUT_W = 6;
    localparam int LTC_OFFSET_W   = $clog2(LTC_TILE_BYTES);
    localparam int LTC_MASK_W     = 8;
    localparam int LTC_IN_W       = 2 * LTC_COORD_W;
    localparam int LTC_IN_BYTES_W = ((LTC_IN_W + 7) / 8) * 8;
    localparam int LTC_OUT_W      = 2 * LTC_TILE_W + LTC_SLOT_OUT_W + 3
                                    + LTC_OFFSET_W + LTC_MASK_W;
    localparam int LTC_OUT_BYTES_W = ((LTC_OUT_W + 7) / 8) * 8;

    // Pixel position inside a tile: bits of a coordinate below the tile select.
    localparam int LTC_IN_TILE_W  = 6;

    // Per-cell control from the top level.
    typedef struct packed {
        logic look;        // compare the key and latch hit and free flags
        logic load_front;  // take the new front entry (cell 0 only)
        logic shift;       // take the entry of the previous cell
    } ltc_ctl_t;

endpackage

`default_nettype wire

// ----- src/lru_tile_cache_pixel_plot.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake         | tdata fields, lowest bit first
// s_      | s_tvalid/s_tready | pixel_x[10:0], pixel_y[10:0], 2 zero bits
// m_      | m_tvalid/m_tready | block_number, hit, buffer_slot, fresh_slot,
//         |                   | evict, victim_block, byte_offset, bit_mask, 2 zero bits
//
// The edge that accepts a word latches the tag compare in every cell, and a later
// edge, once the output register is free, moves the chosen entry to the front of
// the cell chain and loads the output register. The cell chain holds every entry.
// Reset leaves every entry invalid, entry i owning buffer slot i.
// A result that waits on m_tready holds the update; s_tready stays low then.

module lru_tile_cache_pixel_plot
    import ltc_pkg::*;
#(
    parameter int WAYS = LTC_WAYS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // pixel_x[10:0], pixel_y[21:11], zero fill
    input  wire logic [LTC_IN_BYTES_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // block_number[9:0], hit[10], buffer_slot[16:11], fresh_slot[17], evict[18],
    // victim_block[28:19], byte_offset[37:29], bit_mask[45:38], zero fill
    output logic [LTC_OUT_BYTES_W-1:0]      m_tdata
);

    localparam int SLOT_W = $clog2(WAYS);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [LTC_COORD_W-1:0]  pix_x, pix_y;
    logic [LTC_TILE_W-1:0]   in_tile;
    logic [LTC_TILE_W-1:0]   key_reg;
    logic [LTC_TILE_W-1:0]   key;
    logic [LTC_OFFSET_W-1:0] offset_reg;
    logic [LTC_MASK_W-1:0]   mask_reg;
    logic                    accept;
    logic                    commit;

    logic                    cell_valid [WAYS];
    logic [LTC_TILE_W-1:0]   cell_tile  [WAYS];
    logic [SLOT_W-1:0]       cell_slot  [WAYS];
    logic [WAYS-1:0]         hit_vec, free_vec, sel_vec, shift_vec;
    logic                    any_hit, any_free;
    logic [SLOT_W-1:0]       front_slot;
    ltc_ctl_t                ctl [WAYS];

    logic                    out_valid_reg;
    logic [LTC_OUT_W-1:0]    out_data_reg;
    logic [LTC_OUT_W-1:0]    out_data_next;

    // Input word decode.
    assign pix_x    = s_tdata[LTC_COORD_W-1:0];
    assign pix_y    = s_tdata[2*LTC_COORD_W-1:LTC_COORD_W];
    assign in_tile  = {pix_y[LTC_COORD_W-1:LTC_IN_TILE_W],
                       pix_x[LTC_COORD_W-1:LTC_IN_TILE_W]};
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);

    // The cells compare against the incoming tile at accept time.
    assign key = (state_reg == ST_IDLE) ? in_tile : key_reg;

    // Held fields of the word in flight.
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= in_tile;
            offset_reg <= {pix_y[LTC_IN_TILE_W-1:0], pix_x[LTC_IN_TILE_W-1:3]};
            mask_reg   <= LTC_MASK_W'(8'h80 >> pix_x[2:0]);
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_UPDATE;
            ST_UPDATE: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The chain of cells: cell i hands its entry to cell i+1.
    for (genvar i = 0; i < WAYS; i++) begin : g_cell
        logic                  prev_valid;
        logic [LTC_TILE_W-1:0] prev_tile;
        logic [SLOT_W-1:0]     prev_slot;

        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign prev_tile  = key_reg;
            assign prev_slot  = front_slot;
        end else begin : g_body
            assign prev_valid = cell_valid[i-1];
            assign prev_tile  = cell_tile[i-1];
            assign prev_slot  = cell_slot[i-1];
        end

        assign ctl[i].look       = accept;
        assign ctl[i].load_front = commit && (i == 0);
        assign ctl[i].shift      = commit && shift_vec[i];

        ltc_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[i]),
            .key        (key),
            .front_slot (front_slot),
            .prev_valid (prev_valid),
            .prev_tile  (prev_tile),
            .prev_slot  (prev_slot),
            .valid      (cell_valid[i]),
            .tile       (cell_tile[i]),
            .slot       (cell_slot[i]),
            .hit_flag   (hit_vec[i]),
            .free_flag  (free_vec[i])
        );
    end

    ltc_pick #(
        .WAYS (WAYS)
    ) u_pick (
        .hit_vec   (hit_vec),
        .free_vec  (free_vec),
        .sel_vec   (sel_vec),
        .shift_vec (shift_vec),
        .any_hit   (any_hit),
        .any_free  (any_free)
    );

    // Slot of the chosen entry, picked by its one-hot select.
    always_comb begin
        front_slot = '0;
        for (int i = 0; i < WAYS; i++) begin
            front_slot = front_slot | (cell_slot[i] & {SLOT_W{sel_vec[i]}});
        end
    end

    // Result word.
    always_comb begin
        logic                  evict;
        logic                  fresh;
        logic [LTC_TILE_W-1:0] victim;
        evict  = !any_hit && !any_free;
        fresh  = !any_hit && any_free;
        victim = evict ? cell_tile[WAYS-1] : '0;
        out_data_next = {mask_reg, offset_reg, victim, evict, fresh,
                         LTC_SLOT_OUT_W'(front_slot), any_hit, key_reg};
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = LTC_OUT_BYTES_W'(out_data_reg);

    // Exactly one entry is chosen for the update.
    a_one_choice: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> $onehot(sel_vec))
        else $error("entry choice is not one-hot");

    // After an update the front entry holds the looked-up tile.
    a_front_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (cell_valid[0] && (cell_tile[0] == $past(key_reg))))
        else $error("front entry does not hold the new tile");

    // An update never overwrites a result still waiting on the master side.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !commit)
        else $error("result overwritten before it was taken");

    // A word is taken only while no other is being looked up.
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ((state_reg == ST_UPDATE) && !s_tready))
        else $error("second word accepted during an update");

endmodule

`default_nettype wire

// ----- src/ltc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ltc_cell
    import ltc_pkg::*;
#(
    parameter int SLOT_W = 6,
    parameter int INDEX  = 0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ltc_ctl_t              ctl,
    input  wire logic [LTC_TILE_W-1:0] key,
    input  wire logic [SLOT_W-1:0]     front_slot,
    input  wire logic                  prev_valid,
    input  wire logic [LTC_TILE_W-1:0] prev_tile,
    input  wire logic [SLOT_W-1:0]     prev_slot,
    output logic                       valid,
    output logic [LTC_TILE_W-1:0]      tile,
    output logic [SLOT_W-1:0]          slot,
    output logic                       hit_flag,
    output logic                       free_flag
);

    logic                  valid_reg;
    logic [LTC_TILE_W-1:0] tile_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  hit_reg;
    logic                  free_reg;

    // Entry storage: reset leaves the entry invalid and owning its own slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            slot_reg  <= SLOT_W'(INDEX);
        end else if (ctl.load_front) begin
            valid_reg <= 1'b1;
            slot_reg  <= front_slot;
        end else if (ctl.shift) begin
            valid_reg <= prev_valid;
            slot_reg  <= prev_slot;
        end
    end

    // Tile number needs no reset: it is only read while the entry is valid.
    always_ff @(posedge aclk) begin
        if (ctl.load_front) begin
            tile_reg <= key;
        end else if (ctl.shift) begin
            tile_reg <= prev_tile;
        end
    end

    // Lookup flags. Valid entries form a prefix, so the first free entry
    // is the one invalid entry whose predecessor is valid.
    always_ff @(posedge aclk) begin
        if (ctl.look) begin
            hit_reg  <= valid_reg && (tile_reg == key);
            free_reg <= !valid_reg && prev_valid;
        end
    end

    assign valid     = valid_reg;
    assign tile      = tile_reg;
    assign slot      = slot_reg;
    assign hit_flag  = hit_reg;
    assign free_flag = free_reg;

endmodule

`default_nettype wire

// ----- src/ltc_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ltc_pick
    import ltc_pkg::*;
#(
    parameter int WAYS = LTC_WAYS
) (
    input  wire logic [WAYS-1:0] hit_vec,
    input  wire logic [WAYS-1:0] free_vec,
    output logic [WAYS-1:0]      sel_vec,
    output logic [WAYS-1:0]      shift_vec,
    output logic                 any_hit,
    output logic                 any_free
);

    localparam int LEVELS = $clog2(WAYS);

    logic [WAYS-1:0] suf [0:LEVELS];
    logic [WAYS-1:0] last_vec;

    // A hit wins over a free entry; with neither the back entry is reused.
    always_comb begin
        last_vec           = '0;
        last_vec[WAYS-1]   = 1'b1;
        any_hit            = |hit_vec;
        any_free           = |free_vec;
        if (any_hit) begin
            sel_vec = hit_vec;
        end else if (any_free) begin
            sel_vec = free_vec;
        end else begin
            sel_vec = last_vec;
        end
    end

    // Suffix OR in log steps: bit i is set when the chosen entry sits at
    // or behind position i, so cells 1 up to that position move back.
    always_comb begin
        suf[0] = sel_vec;
        for (int k = 0; k < LEVELS; k++) begin
            suf[k+1] = suf[k] | (suf[k] >> (1 << k));
        end
        shift_vec    = suf[LEVELS];
        shift_vec[0] = 1'b0;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ltc_pkg::*;

    localparam int SLOT_W = $clog2(LTC_WAYS);

    // One result word as it sits in m_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [LTC_MASK_W-1:0]     bit_mask;
        logic [LTC_OFFSET_W-1:0]   byte_offset;
        logic [LTC_TILE_W-1:0]     victim_block;
        logic                      evict;
        logic                      fresh_slot;
        logic [LTC_SLOT_OUT_W-1:0] buffer_slot;
        logic                      hit;
        logic [LTC_TILE_W-1:0]     block_number;
    } pixel_result_t;

    // One entry of the move-to-front list.
    typedef struct {
        logic                  valid;
        logic [LTC_TILE_W-1:0] tile;
        logic [SLOT_W-1:0]     slot;
    } tile_way_t;

    logic                       aclk;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [LTC_IN_BYTES_W-1:0]  s_tdata  = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [LTC_OUT_BYTES_W-1:0] m_tdata;

    // Model of the cache list, entry 0 most recently used.
    tile_way_t     lru_way [LTC_WAYS];
    pixel_result_t expected_pixels [$];
    int            error_count = 0;

    // Idle rates of both sides, in percent of cycles.
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;

    // Long receiver hold-off: the test posts a request, the receiver counts it down.
    int unsigned   hold_req_len  = 0;
    int unsigned   hold_req_id   = 0;
    int unsigned   hold_taken_id = 0;
    int unsigned   hold_left     = 0;

    lru_tile_cache_pixel_plot u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("** lru_tile_cache_pixel_plot: FAILED **");
        $finish;
    end

    // Empty list: every entry invalid, entry i owning slot i.
    function automatic void clear_lru();
        for (int i = 0; i < LTC_WAYS; i++) begin
            lru_way[i].valid = 1'b0;
            lru_way[i].tile  = '0;
            lru_way[i].slot  = SLOT_W'(i);
        end
    endfunction

    // Look one pixel up, move its tile to the front and return the word it must produce.
    function automatic pixel_result_t plot_lookup(input logic [LTC_COORD_W-1:0] px,
                                                  input logic [LTC_COORD_W-1:0] py);
        pixel_result_t         r;
        tile_way_t             e;
        logic [LTC_TILE_W-1:0] t;
        int                    pos;
        r   = '0;
        t   = {py[10:6], px[10:6]};
        pos = LTC_WAYS;
        for (int i = 0; i < LTC_WAYS; i++) begin
            if (!lru_way[i].valid) begin
                r.fresh_slot = 1'b1;
                pos = i;
                break;
            end
            if (lru_way[i].tile == t) begin
                r.hit = 1'b1;
                pos = i;
                break;
            end
        end
        // Full list and no match: the back entry is recycled.
        if (pos == LTC_WAYS) begin
            pos            = LTC_WAYS - 1;
            r.evict        = 1'b1;
            r.victim_block = lru_way[pos].tile;
        end
        e       = lru_way[pos];
        e.valid = 1'b1;
        e.tile  = t;
        for (int k = pos; k > 0; k--) begin
            lru_way[k] = lru_way[k-1];
        end
        lru_way[0]     = e;
        r.block_number = t;
        r.buffer_slot  = e.slot[LTC_SLOT_OUT_W-1:0];
        r.byte_offset  = {py[LTC_IN_TILE_W-1:0], px[5:3]};
        r.bit_mask     = 8'h80 >> px[2:0];
        return r;
    endfunction

    // Offer one pixel word, idling first at the sender's rate, and predict its result.
    task automatic send_pixel(input logic [LTC_COORD_W-1:0] px,
                              input logic [LTC_COORD_W-1:0] py);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(LTC_IN_BYTES_W - LTC_IN_W){1'b0}}, py, px};
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(plot_lookup(px, py));
    endtask

    // Random pixel inside a given tile.
    task automatic send_tile_pixel(input logic [LTC_TILE_W-1:0] tile);
        send_pixel({tile[4:0], 6'($urandom_range(63))}, {tile[9:5], 6'($urandom_range(63))});
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic pause_sender();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Corners, every bit position, hits at front and deeper, fills of free slots.
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd7, 11'd63);
        send_pixel(11'd7, 11'd63);
        for (int b = 0; b < 8; b++) begin
            send_pixel(11'(1024 + 9 * b), 11'(1088 + b));
        end
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd64, 11'd64);
        send_pixel(11'd1023, 11'd1024);
        send_pixel(11'd63, 11'd0);
        send_pixel(11'd1985, 11'd1985);
        pause_sender();
    endtask

    // Fill the list with distinct tiles, evict, then hit the entry at the back.
    task automatic test_eviction();
        for (int i = 0; i < 80; i++) begin
            send_tile_pixel(10'((i * 13) % 1024));
        end
        send_tile_pixel(10'((16 * 13) % 1024));
        send_tile_pixel(10'd1000);
        send_tile_pixel(10'((17 * 13) % 1024));
        pause_sender();
    endtask

    // Bursts over working sets of varying size, with some fully random pixels as noise.
    task automatic test_random(input int n, input int tx_pct, input int rx_pct);
        logic [LTC_TILE_W-1:0] pool [128];
        int                    pool_n;
        int                    sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        sent = 0;
        while (sent < n) begin
            pool_n = $urandom_range(4, 100);
            for (int k = 0; k < pool_n; k++) begin
                pool[k] = 10'($urandom_range(1023));
            end
            repeat (60) begin
                if ($urandom_range(9) == 0) begin
                    send_pixel(11'($urandom_range(2047)), 11'($urandom_range(2047)));
                end else begin
                    send_tile_pixel(pool[$urandom_range(pool_n - 1)]);
                end
                sent++;
            end
        end
        pause_sender();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req_len <= 400;
        hold_req_id  <= hold_req_id + 1;
        @(posedge aclk);
        for (int i = 0; i < 40; i++) begin
            send_tile_pixel(10'($urandom_range(90)));
        end
        pause_sender();
    endtask

    // Receiver ready: a posted hold-off first, else random idling.
    always @(posedge aclk) begin
        logic rdy;
        if (hold_req_id != hold_taken_id) begin
            hold_taken_id <= hold_req_id;
            hold_left     <= hold_req_len;
            rdy = 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rdy = 1'b0;
        end else begin
            rdy = ($urandom_range(99) >= rx_idle_pct);
        end
        m_tready <= rdy;
    end

    task automatic compare_field(input string name, input logic [15:0] expv,
                                 input logic [15:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        pixel_result_t got;
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pixel_result_t'(m_tdata[LTC_OUT_W-1:0]);
            if (expected_pixels.size() == 0) begin
                $error("result word with no prediction pending: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("block_number", 16'(want.block_number), 16'(got.block_number));
                compare_field("hit", 16'(want.hit), 16'(got.hit));
                compare_field("buffer_slot", 16'(want.buffer_slot), 16'(got.buffer_slot));
                compare_field("fresh_slot", 16'(want.fresh_slot), 16'(got.fresh_slot));
                compare_field("evict", 16'(want.evict), 16'(got.evict));
                compare_field("victim_block", 16'(want.victim_block), 16'(got.victim_block));
                compare_field("byte_offset", 16'(want.byte_offset), 16'(got.byte_offset));
                compare_field("bit_mask", 16'(want.bit_mask), 16'(got.bit_mask));
            end
        end
    end

    initial begin
        clear_lru();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_eviction();
        test_random(620, 32, 61);
        test_random(620, 61, 32);
        test_backpressure();
        test_random(600, 0, 0);

        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("** lru_tile_cache_pixel_plot: PASSED **");
        end else begin
            $display("** lru_tile_cache_pixel_plot: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ltc_pkg.sv
src/ltc_cell.sv
src/ltc_pick.sv
src/lru_tile_cache_pixel_plot.sv
tb/sv/tb_top.sv
